FILE: hdl/btff_pkg.sv
// ----------------------------------------------------------------------------
// btff_pkg
// Types, codes and sizes shared by the boundary-tag first-fit allocator.
// ----------------------------------------------------------------------------
package btff_pkg;

  // heap geometry
  localparam int HEAP_WORDS = 2048;
  localparam int AW = $clog2(HEAP_WORDS);  // word address width
  localparam int TW = AW + 1;              // signed tag width
  localparam int CW = AW + 2;              // walk arithmetic width

  // command codes
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_REINIT = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [13:0] request_bytes;
    logic [10:0] release_word;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] granted_word;
    logic [12:0] free_bytes;
    logic [12:0] used_bytes;
  } out_beat_t;

  // tag memory access, one write and one read port
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [TW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

endpackage

FILE: hdl/btff_tag_ram.sv
// ----------------------------------------------------------------------------
// btff_tag_ram
// Tag store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btff_tag_ram (
  input  logic                      clk,
  input  btff_pkg::ram_req_t        req,
  output logic [btff_pkg::TW-1:0]   rdata
);
  import btff_pkg::*;

  logic [TW-1:0] mem [HEAP_WORDS];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: hdl/btff_ctrl.sv
// ----------------------------------------------------------------------------
// btff_ctrl
// Sequencer: walks block tags in the tag store, splits, merges and keeps
// running word counts; holds the result beat in an output register.
// ----------------------------------------------------------------------------
module btff_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  btff_pkg::in_beat_t       in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output btff_pkg::out_beat_t      out_data,
  output btff_pkg::ram_req_t       ram_req,
  input  logic [btff_pkg::TW-1:0]  ram_rdata
);
  import btff_pkg::*;

  typedef enum logic [17:0] {
    S_INIT0 = 18'b000000000000000001,
    S_INIT1 = 18'b000000000000000010,
    S_IDLE  = 18'b000000000000000100,
    S_ARD   = 18'b000000000000001000,
    S_AEV   = 18'b000000000000010000,
    S_AW0   = 18'b000000000000100000,
    S_AW1   = 18'b000000000001000000,
    S_AW2   = 18'b000000000010000000,
    S_AW3   = 18'b000000000100000000,
    S_FRD   = 18'b000000001000000000,
    S_FEV   = 18'b000000010000000000,
    S_FPRD  = 18'b000000100000000000,
    S_FPEV  = 18'b000001000000000000,
    S_FNRD  = 18'b000010000000000000,
    S_FNEV  = 18'b000100000000000000,
    S_FW    = 18'b001000000000000000,
    S_FW1   = 18'b010000000000000000,
    S_RESP  = 18'b100000000000000000
  } state_t;

  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_WORDS);
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [CW-1:0] TWO_C  = CW'(2);

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] spare_r, spare_nxt;
  logic          split_r, split_nxt;
  logic          reinit_r, reinit_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [AW-1:0] res_grant_r, res_grant_nxt;
  logic [AW-1:0] fc_r, fc_nxt;
  logic [AW-1:0] uc_r, uc_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;

  // decoded tag and walk sums
  logic          tneg;
  logic [CW-1:0] tsx, tmag, iend, nb, wa;
  logic [CW-1:0] word_x, need_in;

  always_comb begin
    tneg    = ram_rdata[TW-1];
    tsx     = {{(CW-TW){ram_rdata[TW-1]}}, ram_rdata};
    tmag    = tneg ? (~tsx + ONE_C) : tsx;
    iend    = i_r + tmag + TWO_C;
    nb      = start_r + size_r + TWO_C;
    word_x  = CW'(in_data.release_word);
    need_in = CW'((15'(in_data.request_bytes) + 15'd3) >> 2);
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    s_nxt          = s_r;
    need_nxt       = need_r;
    size_nxt       = size_r;
    start_nxt      = start_r;
    spare_nxt      = spare_r;
    split_nxt      = split_r;
    reinit_nxt     = reinit_r;
    res_status_nxt = res_status_r;
    res_grant_nxt  = res_grant_r;
    fc_nxt         = fc_r;
    uc_nxt         = uc_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_req        = '0;
    wa             = '0;
    in_ready       = (state_r == S_IDLE);

    unique case (state_r)
      S_INIT0: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = TW'(HEAP_WORDS - 2);
        state_nxt     = S_INIT1;
      end
      S_INIT1: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = AW'(HEAP_WORDS - 1);
        ram_req.wdata = TW'(HEAP_WORDS - 2);
        state_nxt     = reinit_r ? S_RESP : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = ST_INVALID;
          res_grant_nxt  = '0;
          i_nxt          = '0;
          unique case (in_data.command)
            CMD_ALLOC: begin
              need_nxt  = need_in;
              state_nxt = (need_in == '0) ? S_RESP : S_ARD;
            end
            CMD_FREE: begin
              s_nxt     = word_x - ONE_C;
              state_nxt = (word_x == '0 || word_x >= HEAP_C) ? S_RESP : S_FRD;
            end
            CMD_REINIT: begin
              fc_nxt         = AW'(HEAP_WORDS - 2);
              uc_nxt         = '0;
              reinit_nxt     = 1'b1;
              res_status_nxt = ST_DONE;
              state_nxt      = S_INIT0;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      // allocate: walk blocks from word 0
      S_ARD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = i_r[AW-1:0];
        state_nxt     = S_AEV;
      end
      S_AEV: begin
        if (iend > HEAP_C) begin
          res_status_nxt = ST_NOFIT;
          state_nxt      = S_RESP;
        end else if (!tneg && tmag >= need_r) begin
          size_nxt       = tmag;
          spare_nxt      = tmag - need_r;
          split_nxt      = (tmag - need_r) >= TWO_C;
          res_status_nxt = ST_DONE;
          res_grant_nxt  = i_r[AW-1:0] + AW'(1);
          if ((tmag - need_r) >= TWO_C) begin
            fc_nxt = fc_r - need_r[AW-1:0] - AW'(2);
            uc_nxt = uc_r + need_r[AW-1:0];
          end else begin
            fc_nxt = fc_r - tmag[AW-1:0];
            uc_nxt = uc_r + tmag[AW-1:0];
          end
          state_nxt = S_AW0;
        end else begin
          i_nxt = iend;
          if (iend < HEAP_C) begin
            state_nxt = S_ARD;
          end else begin
            res_status_nxt = ST_NOFIT;
            state_nxt      = S_RESP;
          end
        end
      end
      // write the used block's tags, then the spare block's
      S_AW0: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = i_r[AW-1:0];
        ram_req.wdata = split_r ? TW'(~need_r + ONE_C) : TW'(~size_r + ONE_C);
        state_nxt     = S_AW1;
      end
      S_AW1: begin
        wa            = i_r + (split_r ? need_r : size_r) + ONE_C;
        ram_req.we    = (wa < HEAP_C);
        ram_req.waddr = wa[AW-1:0];
        ram_req.wdata = split_r ? TW'(~need_r + ONE_C) : TW'(~size_r + ONE_C);
        state_nxt     = split_r ? S_AW2 : S_RESP;
      end
      S_AW2: begin
        wa            = i_r + need_r + TWO_C;
        ram_req.we    = (wa < HEAP_C);
        ram_req.waddr = wa[AW-1:0];
        ram_req.wdata = TW'(spare_r - TWO_C);
        state_nxt     = S_AW3;
      end
      S_AW3: begin
        wa            = i_r + size_r + ONE_C;
        ram_req.we    = (wa < HEAP_C);
        ram_req.waddr = wa[AW-1:0];
        ram_req.wdata = TW'(spare_r - TWO_C);
        state_nxt     = S_RESP;
      end
      // free: walk to the block start
      S_FRD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = i_r[AW-1:0];
        state_nxt     = S_FEV;
      end
      S_FEV: begin
        if (iend > HEAP_C) begin
          state_nxt = S_RESP;
        end else if (i_r == s_r) begin
          if (tneg) begin
            size_nxt       = tmag;
            start_nxt      = s_r;
            uc_nxt         = uc_r - tmag[AW-1:0];
            fc_nxt         = fc_r + tmag[AW-1:0];
            res_status_nxt = ST_DONE;
            state_nxt      = (s_r != '0) ? S_FPRD : S_FNRD;
          end else begin
            state_nxt = S_RESP;
          end
        end else begin
          i_nxt     = iend;
          state_nxt = (iend < HEAP_C && iend <= s_r) ? S_FRD : S_RESP;
        end
      end
      // merge with the free block below
      S_FPRD: begin
        ram_req.re    = 1'b1;
        wa            = s_r - ONE_C;
        ram_req.raddr = wa[AW-1:0];
        state_nxt     = S_FPEV;
      end
      S_FPEV: begin
        if (!tneg && (tmag + TWO_C) <= s_r) begin
          start_nxt = s_r - tmag - TWO_C;
          size_nxt  = size_r + tmag + TWO_C;
          fc_nxt    = fc_r + AW'(2);
        end
        state_nxt = S_FNRD;
      end
      // merge with the free block above
      S_FNRD: begin
        if (nb < HEAP_C) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = nb[AW-1:0];
          state_nxt     = S_FNEV;
        end else begin
          state_nxt = S_FW;
        end
      end
      S_FNEV: begin
        if (!tneg && (nb + tmag + ONE_C) < HEAP_C) begin
          size_nxt = size_r + tmag + TWO_C;
          fc_nxt   = fc_r + AW'(2);
        end
        state_nxt = S_FW;
      end
      // write the merged free block's low tag, then its high tag
      S_FW: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = start_r[AW-1:0];
        ram_req.wdata = size_r[TW-1:0];
        state_nxt     = S_FW1;
      end
      S_FW1: begin
        wa            = start_r + size_r + ONE_C;
        ram_req.we    = (wa < HEAP_C);
        ram_req.waddr = wa[AW-1:0];
        ram_req.wdata = size_r[TW-1:0];
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.granted_word = res_grant_r;
          out_data_nxt.free_bytes   = {fc_r, 2'b00};
          out_data_nxt.used_bytes   = {uc_r, 2'b00};
          reinit_nxt                = 1'b0;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT0;
      reinit_r    <= 1'b0;
      fc_r        <= AW'(HEAP_WORDS - 2);
      uc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reinit_r    <= reinit_nxt;
      fc_r        <= fc_nxt;
      uc_r        <= uc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    s_r          <= s_nxt;
    need_r       <= need_nxt;
    size_r       <= size_nxt;
    start_r      <= start_nxt;
    spare_r      <= spare_nxt;
    split_r      <= split_nxt;
    res_status_r <= res_status_nxt;
    res_grant_r  <= res_grant_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/boundary_tag_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// First-fit heap allocator over a tag store with signed boundary tags.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            beat
//   in_      input      in_valid/in_ready    in_beat_t (command, bytes, word)
//   out_     output     out_valid/out_ready  out_beat_t (status, word, counts)
//
// Allocate and free walk the heap one block at a time (tag read, then
// evaluate), bounded by the single tag memory read port; an allocate adds
// two or four tag writes, a free up to two merge reads and two tag writes.
// Reinitialize rewrites the two end tags; after reset they are written
// before in_ready rises. A new beat is taken while a result waits at out_.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  btff_pkg::in_beat_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output btff_pkg::out_beat_t   out_data
);
  import btff_pkg::*;

  ram_req_t      ram_req;
  logic [TW-1:0] ram_rdata;

  btff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  btff_tag_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

FILE: hdl/btff_checker.sv
// ----------------------------------------------------------------------------
// btff_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module btff_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input btff_pkg::in_beat_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input btff_pkg::out_beat_t  out_data
);
  import btff_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // a failed step grants nothing
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |-> out_data.granted_word == '0)
    else $error("grant reported on a failed step");

  // free and used data never exceed the heap less its end tags
  a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (15'(out_data.free_bytes) + 15'(out_data.used_bytes))
                  <= 15'((HEAP_WORDS - 2) * 4))
    else $error("free plus used bytes exceed heap");

  // hold a waiting input beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat dropped or changed while waiting");

endmodule

bind boundary_tag_first_fit_allocator btff_checker u_btff_checker (.*);

FILE: verif/boundary_tag_first_fit_allocator_tb.sv
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_tb
// Self-checking bench: drives allocate, free and reinitialize beats with random
// idling on both channels, predicts every result with a local heap model and
// compares it field by field.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_tb;
  import btff_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;

  boundary_tag_first_fit_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // heap model
  int heap_tag [HEAP_WORDS];
  int free_words;
  int used_words;
  int live_blocks [$];   // data words of granted blocks
  out_beat_t pending_results [$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int n_alloc = 0, n_free = 0, n_reinit = 0, n_nofit = 0, n_invalid = 0;
  bit idle_on = 1'b1;
  longint cycles = 0;

  function automatic int span_of(int t);
    return ((t < 0) ? -t : t) + 2;
  endfunction

  function automatic void set_tags(int start, int size, int value);
    if (start < HEAP_WORDS) heap_tag[start] = value;
    if (start + size + 1 < HEAP_WORDS) heap_tag[start + size + 1] = value;
  endfunction

  function automatic void reset_heap_model();
    foreach (heap_tag[k]) heap_tag[k] = 0;
    set_tags(0, HEAP_WORDS - 2, HEAP_WORDS - 2);
    free_words = HEAP_WORDS - 2;
    used_words = 0;
  endfunction

  function automatic logic [1:0] model_alloc(int bytes, output int granted);
    int need, i, t, spare;
    need = (bytes + 3) / 4;
    granted = 0;
    i = 0;
    if (need == 0) return ST_INVALID;
    while (i < HEAP_WORDS) begin
      t = heap_tag[i];
      if (i + span_of(t) > HEAP_WORDS) break;
      if (t >= 0 && t >= need) begin
        spare = t - need;
        if (spare >= 2) begin
          set_tags(i, need, -need);
          set_tags(i + need + 2, spare - 2, spare - 2);
          free_words -= need + 2;
          used_words += need;
        end else begin
          set_tags(i, t, -t);
          free_words -= t;
          used_words += t;
        end
        granted = i + 1;
        return ST_DONE;
      end
      i += span_of(t);
    end
    return ST_NOFIT;
  endfunction

  function automatic logic [1:0] model_free(int word);
    int s, i, t, size, start, last, p, q;
    bit found;
    found = 1'b0;
    i = 0;
    if (word == 0 || word >= HEAP_WORDS) return ST_INVALID;
    s = word - 1;
    while (i < HEAP_WORDS && i <= s) begin
      t = heap_tag[i];
      if (i + span_of(t) > HEAP_WORDS) break;
      if (i == s) begin
        found = (t < 0);
        break;
      end
      i += span_of(t);
    end
    if (!found) return ST_INVALID;
    size = -heap_tag[s];
    used_words -= size;
    free_words += size;
    start = s;
    // merge with free block below
    if (s > 0 && heap_tag[s - 1] >= 0) begin
      p = heap_tag[s - 1];
      if (p + 2 <= s) begin
        start = s - p - 2;
        size += p + 2;
        free_words += 2;
      end
    end
    // merge with free block above
    last = start + size + 1;
    if (last + 1 < HEAP_WORDS && heap_tag[last + 1] >= 0) begin
      q = heap_tag[last + 1];
      if (last + 1 + q + 1 < HEAP_WORDS) begin
        size += q + 2;
        free_words += 2;
      end
    end
    set_tags(start, size, size);
    return ST_DONE;
  endfunction

  function automatic out_beat_t predict_result(in_beat_t b);
    out_beat_t r;
    int granted;
    granted = 0;
    case (b.command)
      CMD_ALLOC: begin
        r.status = model_alloc(int'(b.request_bytes), granted);
        if (r.status == ST_DONE) live_blocks.push_back(granted);
      end
      CMD_FREE: r.status = model_free(int'(b.release_word));
      CMD_REINIT: begin
        reset_heap_model();
        r.status = ST_DONE;
      end
      default: r.status = ST_INVALID;
    endcase
    r.granted_word = granted[10:0];
    r.free_bytes = 13'(free_words * 4);
    r.used_bytes = 13'(used_words * 4);
    return r;
  endfunction

  // random gap, sometimes none; drop valid while idling
  task automatic maybe_idle();
    if (idle_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
  endtask

  // send one beat and record its expected result; returns at a falling edge
  task automatic send_beat(logic [1:0] cmd, int bytes, int word);
    in_beat_t b;
    b.command = cmd;
    b.request_bytes = bytes[13:0];
    b.release_word = word[10:0];
    maybe_idle();
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_result(b));
    beats_sent++;
    case (cmd)
      CMD_ALLOC: n_alloc++;
      CMD_FREE: n_free++;
      CMD_REINIT: n_reinit++;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_alloc(int bytes);
    send_beat(CMD_ALLOC, bytes, $urandom_range(2047));
  endtask

  // free a live block, dropping it from the list
  task automatic send_release(int idx);
    int w;
    w = live_blocks[idx];
    live_blocks.delete(idx);
    send_beat(CMD_FREE, $urandom_range(16383), w);
  endtask

  task automatic send_reinit();
    send_beat(CMD_REINIT, $urandom_range(16383), $urandom_range(2047));
    live_blocks.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // receiver: random stalls, compare each beat
  always @(negedge clk) begin
    if (idle_on && $urandom_range(4) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    out_beat_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        beats_checked++;
        if (e.status == ST_NOFIT) n_nofit++;
        if (e.status == ST_INVALID) n_invalid++;
        if (out_data.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
        if (out_data.granted_word !== e.granted_word)
          $display("%0t: granted_word expected %0d actual %0d", $time, e.granted_word,
                   out_data.granted_word);
        if (out_data.free_bytes !== e.free_bytes)
          $display("%0t: free_bytes expected %0d actual %0d", $time, e.free_bytes,
                   out_data.free_bytes);
        if (out_data.used_bytes !== e.used_bytes)
          $display("%0t: used_bytes expected %0d actual %0d", $time, e.used_bytes,
                   out_data.used_bytes);
        if (out_data !== e) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("boundary_tag_first_fit_allocator regression: fail");
      $finish;
    end
  end

  // extremes, every command, and each special case
  task automatic test_directed();
    send_alloc(0);                          // zero request
    send_alloc(8192);                       // too large
    send_alloc(16383);                      // all request bits set
    send_alloc(1);
    send_alloc(4);
    send_alloc(5);
    send_alloc(20);
    send_beat(CMD_FREE, 0, 0);              // word zero
    send_beat(CMD_FREE, 0, 2047);           // top word: not a block start
    send_beat(CMD_FREE, 0, 3);              // inside a block
    send_release(1);                        // free, merge above pending
    send_release(0);                        // merge with neighbour
    send_beat(CMD_FREE, 0, 1);              // already free
    send_beat(2'd3, 16383, 2047);           // unused command
    send_alloc(8184);                       // whole heap size: no fit while blocks are live
    send_alloc(4);                          // small request fits
    send_release(0);
    send_alloc(8176);                       // no fit while blocks are live
    send_alloc(4);                          // small request, split
    send_reinit();
    send_alloc(8180);                       // spare of one: no split
    send_reinit();
    send_beat(CMD_FREE, 0, 1);              // fresh heap: free block
    drain();
  endtask

  // mostly well-formed alloc/free with random content, some noise
  task automatic test_random(int count, bit bursty);
    int r;
    idle_on = bursty;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 45) begin
        if ($urandom_range(9) == 0) send_alloc($urandom_range(8192, 1024));
        else send_alloc($urandom_range(200, 1));
      end else if (r < 85 && live_blocks.size() != 0)
        send_release($urandom_range(live_blocks.size() - 1));
      else if (r < 93)
        send_beat(CMD_FREE, $urandom_range(16383), $urandom_range(2047));
      else if (r < 96)
        send_beat(2'(r[0] ? 3 : 0), r[1] ? 0 : $urandom_range(16383), $urandom_range(2047));
      else send_reinit();
    end
  endtask

  initial begin
    reset_heap_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(250, 1'b1);
    drain();                                // sender waits for every result
    test_random(250, 1'b1);
    test_random(60, 1'b0);
    drain();
    $display("sent %0d beats, checked %0d: %0d alloc, %0d free, %0d reinit",
             beats_sent, beats_checked, n_alloc, n_free, n_reinit);
    $display("no-fit results %0d, invalid results %0d", n_nofit, n_invalid);
    if (errors == 0 && pending_results.size() == 0)
      $display("boundary_tag_first_fit_allocator regression: pass");
    else
      $display("boundary_tag_first_fit_allocator regression: fail");
    $finish;
  end
endmodule
